FILE: rtl/core/sad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Static arithmetic decoder package
// Sizes, codes and item types shared by the decoder front, back and top.
// ----------------------------------------------------------------------------
package sad_pkg;

	localparam int PRECISION_BITS = 32;
	localparam int MAX_SYMBOLS    = 256;
	localparam int FRACTION_BITS  = 16;
	localparam int MAX_RUN        = 16;

	// derived sizes
	localparam int ST_W      = PRECISION_BITS + 1;
	localparam int CUM_DEPTH = MAX_SYMBOLS + 1;
	localparam int CUM_AW    = $clog2(CUM_DEPTH);
	localparam int VAL_AW    = $clog2(MAX_SYMBOLS);
	localparam int FRAC_W    = FRACTION_BITS + 1;
	localparam int CNT_W     = $clog2(MAX_RUN + 1);
	localparam int PRE_W     = $clog2(PRECISION_BITS + 1);
	localparam int PH_W      = ST_W - FRACTION_BITS + FRAC_W;
	localparam int PL_W      = FRACTION_BITS + FRAC_W;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);

	// interval constants
	localparam logic [ST_W-1:0] WHOLE_V   = ST_W'(1) << PRECISION_BITS;
	localparam logic [ST_W-1:0] HALF_V    = ST_W'(1) << (PRECISION_BITS - 1);
	localparam logic [ST_W-1:0] QUARTER_V = ST_W'(1) << (PRECISION_BITS - 2);
	localparam logic [ST_W-1:0] Q3_V      = HALF_V + QUARTER_V;
	localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRACTION_BITS;
	localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_W'(1) << (FRACTION_BITS - 1);
	localparam logic [31:0] STOP_CODE = 32'hFFFF_FFFD;

	// input commands
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_BIT    = 2'd2;
	localparam logic [1:0] CMD_IGNORE = 2'd3;

	// decode phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PRELOAD = 2'd1;
	localparam logic [1:0] PH_HALF    = 2'd2;
	localparam logic [1:0] PH_QUARTER = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [8:0]         entry_index;
		logic [16:0]        cum_fraction;
		logic signed [31:0] entry_value;
		logic               coded_bit;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] symbol_value;
		logic               last_of_run;
		logic               stream_done;
		logic               run_overflow;
	} out_item_t;

	// classified item between front and back
	typedef struct packed {
		logic [1:0]        kind;
		logic              cum_we;
		logic              val_we;
		logic [CUM_AW-1:0] idx;
		logic [FRAC_W-1:0] frac;
		logic [31:0]       value;
		logic              bit_in;
	} q_entry_t;

endpackage

FILE: rtl/core/static_arithmetic_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Static arithmetic decoder
// Decodes a static-model arithmetic-coded bit stream, one bit per item.
// ----------------------------------------------------------------------------
// Usage: write symbol_count on the cfg channel while the block is idle, load
// table entries (cmd load), then send start and the coded bits. Items enter
// through in_valid/in_stall into a two-entry queue; results leave on
// out_valid/out_stall, each holding until taken.
// A load, start or preload bit is handled in the back's pop state. Each
// symbol found at entry k takes k+2 bound computations, each a RAM read,
// multiply, add and compare in one shared bound unit, plus search setup,
// value read and the following rescale check. A bit that triggers decoding
// also passes through pop, check and finish around its symbols. A bit with
// a rescale only passes through pop, check and finish.
// Each bit may give up to MAX_RUN results; the last carries last_of_run.
// Reset clears the queue, the output register and the decoder to idle; the
// table contents stay undefined until loaded, symbol_count resets to 1.
// A stalled receiver holds the output; the back then waits, the queue fills
// and in_stall rises.
// ----------------------------------------------------------------------------
module static_arithmetic_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sad_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output sad_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         cfg_data
);

	logic [8:0]        sym_cnt_q;
	logic              q_valid;
	logic              q_pop;
	sad_pkg::q_entry_t q_entry;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_cnt_q <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			sym_cnt_q <= cfg_data;
		end
	end

	sad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	sad_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol_count (sym_cnt_q),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item)
	);

endmodule

FILE: rtl/core/sad_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/sad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder front
// Accepts input items, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module sad_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sad_pkg::in_item_t in_item,
	output logic              q_valid,
	output sad_pkg::q_entry_t q_entry,
	input  logic              q_pop
);

	sad_pkg::q_entry_t                  q_mem [sad_pkg::QDEPTH];
	logic [sad_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [sad_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [sad_pkg::QPTR_W:0]           cnt_q;
	sad_pkg::q_entry_t                  cls;
	logic                               keep;
	logic                               push;
	logic                               pop;

	// classify the incoming item
	always_comb begin
		cls        = '0;
		keep       = 1'b1;
		cls.idx    = sad_pkg::CUM_AW'(in_item.entry_index);
		cls.frac   = (in_item.cum_fraction > sad_pkg::FRAC_ONE) ?
			sad_pkg::FRAC_ONE : in_item.cum_fraction;
		cls.value  = in_item.entry_value;
		cls.bit_in = in_item.coded_bit;
		cls.kind   = in_item.cmd;
		unique case (in_item.cmd)
			sad_pkg::CMD_LOAD: begin
				cls.cum_we = 32'(in_item.entry_index) <= sad_pkg::MAX_SYMBOLS;
				cls.val_we = 32'(in_item.entry_index) < sad_pkg::MAX_SYMBOLS;
			end
			sad_pkg::CMD_START, sad_pkg::CMD_BIT: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = (cnt_q == (sad_pkg::QPTR_W+1)'(sad_pkg::QDEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = q_mem[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/sad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder back
// Runs table loads, stream restarts, rescaling and the symbol search.
// ----------------------------------------------------------------------------
module sad_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [8:0]         symbol_count,
	input  logic               q_valid,
	input  sad_pkg::q_entry_t  q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output sad_pkg::out_item_t out_item
);

	localparam logic [3:0] S_POP   = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SINIT = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_ADD   = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_VAL   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0]                      state_q;
	logic [sad_pkg::ST_W-1:0]        low_q, high_q, code_q, w_q, lo_q, hi_q, bnd_q;
	logic [sad_pkg::PRE_W-1:0]       pre_q;
	logic [1:0]                      phase_q;
	logic                            skip_half_q;
	logic [sad_pkg::CNT_W-1:0]       cnt_q;
	logic [sad_pkg::CUM_AW:0]        e_q;
	logic [sad_pkg::PH_W-1:0]        prod_h_q;
	logic [sad_pkg::PL_W-1:0]        prod_l_q;
	sad_pkg::out_item_t              pend_q, out_q, push_data;
	logic                            pend_vld_q, out_vld_q;
	logic                            can_push, push_en;
	logic [sad_pkg::FRAC_W-1:0]      cum_rdata;
	logic [31:0]                     val_rdata;
	logic                            ram_we_cum, ram_we_val;
	logic [31:0]                     n_eff;
	logic [sad_pkg::ST_W-1:0]        off, low_n, high_n, code_n, hi_c;
	logic                            half_due, qtr_due, hit;

	// table memories
	sad_ram #(.WIDTH(sad_pkg::FRAC_W), .DEPTH(sad_pkg::CUM_DEPTH)) u_cum_ram (
		.clk   (clk),
		.we    (ram_we_cum),
		.waddr (q_entry.idx),
		.wdata (q_entry.frac),
		.raddr (e_q[sad_pkg::CUM_AW-1:0]),
		.rdata (cum_rdata)
	);

	sad_ram #(.WIDTH(32), .DEPTH(sad_pkg::MAX_SYMBOLS)) u_val_ram (
		.clk   (clk),
		.we    (ram_we_val),
		.waddr (sad_pkg::VAL_AW'(q_entry.idx)),
		.wdata (q_entry.value),
		.raddr (sad_pkg::VAL_AW'(e_q - (sad_pkg::CUM_AW+1)'(1))),
		.rdata (val_rdata)
	);

	assign q_pop      = (state_q == S_POP) && q_valid;
	assign ram_we_cum = q_pop && (q_entry.kind == sad_pkg::CMD_LOAD) && q_entry.cum_we;
	assign ram_we_val = q_pop && (q_entry.kind == sad_pkg::CMD_LOAD) && q_entry.val_we;

	// rescale arithmetic and search compare
	always_comb begin
		n_eff = (32'(symbol_count) > sad_pkg::MAX_SYMBOLS) ?
			32'(sad_pkg::MAX_SYMBOLS) : 32'(symbol_count);
		if (phase_q == sad_pkg::PH_HALF) begin
			off = (high_q < sad_pkg::HALF_V) ? '0 : sad_pkg::HALF_V;
		end else begin
			off = sad_pkg::QUARTER_V;
		end
		low_n    = (low_q - off) << 1;
		high_n   = (high_q - off) << 1;
		code_n   = ((code_q - off) << 1) | sad_pkg::ST_W'(q_entry.bit_in);
		half_due = (high_q < sad_pkg::HALF_V) || (low_q > sad_pkg::HALF_V);
		qtr_due  = (low_q > sad_pkg::QUARTER_V) && (high_q < sad_pkg::Q3_V);
		hi_c     = low_q + bnd_q;
		hit      = (code_q >= lo_q) && (code_q < hi_c);
	end

	// output slot
	always_comb begin
		can_push  = !out_vld_q || !out_stall;
		push_en   = pend_vld_q && can_push && ((state_q == S_SINIT) || (state_q == S_FIN));
		push_data = pend_q;
		push_data.last_of_run = (state_q == S_FIN);
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (push_en) out_q <= push_data;
		unique case (state_q)
			S_SINIT: w_q <= high_q - low_q;
			S_MUL: begin
				prod_h_q <= sad_pkg::PH_W'(w_q[sad_pkg::ST_W-1:sad_pkg::FRACTION_BITS]) *
					sad_pkg::PH_W'(cum_rdata);
				prod_l_q <= sad_pkg::PL_W'(w_q[sad_pkg::FRACTION_BITS-1:0]) *
					sad_pkg::PL_W'(cum_rdata);
			end
			S_ADD: begin
				bnd_q <= sad_pkg::ST_W'(prod_h_q + sad_pkg::PH_W'(
					(prod_l_q + sad_pkg::PL_W'(sad_pkg::FRAC_HALF)) >> sad_pkg::FRACTION_BITS));
			end
			S_CMP: begin
				if (e_q == '0 || !hit) lo_q <= hi_c;
				else                   hi_q <= hi_c;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_POP;
			low_q       <= '0;
			high_q      <= sad_pkg::WHOLE_V;
			code_q      <= '0;
			pre_q       <= '0;
			phase_q     <= sad_pkg::PH_IDLE;
			skip_half_q <= 1'b0;
			cnt_q       <= '0;
			e_q         <= '0;
			pend_q      <= '0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (push_en)        out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
			unique case (state_q)
				S_POP: begin
					if (q_pop) begin
						if (q_entry.kind == sad_pkg::CMD_START) begin
							low_q   <= '0;
							high_q  <= sad_pkg::WHOLE_V;
							code_q  <= '0;
							pre_q   <= '0;
							phase_q <= sad_pkg::PH_PRELOAD;
						end else if (q_entry.kind == sad_pkg::CMD_BIT) begin
							cnt_q <= '0;
							if (phase_q == sad_pkg::PH_PRELOAD) begin
								code_q <= {code_q[sad_pkg::ST_W-2:0], q_entry.bit_in};
								pre_q  <= pre_q + 1'b1;
								if (pre_q == sad_pkg::PRE_W'(sad_pkg::PRECISION_BITS - 1)) begin
									state_q <= S_SINIT;
								end
							end else if (phase_q != sad_pkg::PH_IDLE) begin
								low_q       <= low_n;
								high_q      <= high_n;
								code_q      <= code_n;
								skip_half_q <= (phase_q == sad_pkg::PH_QUARTER);
								state_q     <= S_CHECK;
							end
						end
					end
				end
				S_CHECK: begin
					if (!skip_half_q && half_due) begin
						phase_q <= sad_pkg::PH_HALF;
						state_q <= S_FIN;
					end else if (qtr_due) begin
						phase_q <= sad_pkg::PH_QUARTER;
						state_q <= S_FIN;
					end else if (32'(cnt_q) >= sad_pkg::MAX_RUN) begin
						pend_q.run_overflow <= 1'b1;
						phase_q <= sad_pkg::PH_IDLE;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SINIT;
					end
				end
				S_SINIT: begin
					// flush the previous symbol; it is not the last one
					if (!pend_vld_q || can_push) begin
						pend_vld_q <= 1'b0;
						e_q        <= '0;
						state_q    <= S_RD;
					end
				end
				S_RD: begin
					if (32'(e_q) > n_eff) begin
						pend_q     <= '{symbol_value: '0, last_of_run: 1'b0,
							stream_done: 1'b0, run_overflow: 1'b1};
						pend_vld_q <= 1'b1;
						phase_q    <= sad_pkg::PH_IDLE;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= S_CMP;
				S_CMP: begin
					if (e_q != '0 && hit) begin
						state_q <= S_VAL;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_VAL: begin
					pend_vld_q <= 1'b1;
					if (val_rdata == sad_pkg::STOP_CODE) begin
						pend_q  <= '{symbol_value: '0, last_of_run: 1'b0,
							stream_done: 1'b1, run_overflow: 1'b0};
						phase_q <= sad_pkg::PH_IDLE;
						state_q <= S_FIN;
					end else begin
						pend_q      <= '{symbol_value: val_rdata, last_of_run: 1'b0,
							stream_done: 1'b0, run_overflow: 1'b0};
						low_q       <= lo_q;
						high_q      <= hi_q;
						cnt_q       <= cnt_q + 1'b1;
						skip_half_q <= 1'b0;
						state_q     <= S_CHECK;
					end
				end
				S_FIN: begin
					if (!pend_vld_q || can_push) begin
						pend_vld_q <= 1'b0;
						state_q    <= S_POP;
					end
				end
				default: state_q <= S_POP;
			endcase
		end
	end

endmodule

FILE: rtl/core/sad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the top level ports for output handshake and result flag rules.
// ----------------------------------------------------------------------------
module sad_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input sad_pkg::out_item_t out_item
);

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	// a stop result closes the run and carries no symbol
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stream_done |->
			out_item.last_of_run && !out_item.run_overflow && out_item.symbol_value == 0)
		else $error("stop result malformed");

	// an abandoned run ends on the flagged item
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.run_overflow |-> out_item.last_of_run)
		else $error("overflow not on last item");

	// output idle right after reset
	a_rst_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid out of reset");

endmodule

bind static_arithmetic_decoder sad_checker u_sad_checker (.*);
